// ===== hw/rtl/otr_pkg.sv =====
package otr_pkg;

    localparam int TIME_W    = 24;
    localparam int PAYLOAD_W = 64;
    localparam int ID_W      = 32;
    localparam int COUNT_W   = 6;
    localparam int KIND_W    = 2;
    localparam int TYPE_W    = 2;
    localparam int ENTRY_W   = ID_W + TIME_W + PAYLOAD_W;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_STORE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUMP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    // Result types
    localparam logic [TYPE_W-1:0] RES_DUMP   = 2'd0;
    localparam logic [TYPE_W-1:0] RES_WINDOW = 2'd1;
    localparam logic [TYPE_W-1:0] RES_IMPACT = 2'd2;
    localparam logic [TYPE_W-1:0] RES_EMPTY  = 2'd3;

    // Configuration register index (word address bit) and reset value
    localparam logic              REG_WINDOW    = 1'b0;
    localparam logic [TIME_W-1:0] WINDOW_RESET  = 24'd480;

    // Command handed from the front part to the back part
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [TIME_W-1:0]    sample_time;
        logic [PAYLOAD_W-1:0] record_payload;
        logic [TIME_W-1:0]    query_time;
    } t_cmd;

    // One stored ring entry
    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_W-1:0]    etime;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

endpackage

// ===== hw/rtl/otr_ram.sv =====
module otr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/otr_front.sv =====
module otr_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [otr_pkg::KIND_W-1:0]         i_kind,
    input  logic [otr_pkg::TIME_W-1:0]         i_sample_time,
    input  logic [otr_pkg::PAYLOAD_W-1:0]      i_record_payload,
    input  logic [otr_pkg::TIME_W-1:0]         i_query_time,
    output logic                               o_cmd_valid,
    output otr_pkg::t_cmd                      o_cmd,
    input  logic                               i_cmd_pop
);

    otr_pkg::t_cmd r_q [2];
    logic          r_wr_idx;
    logic          r_rd_idx;
    logic [1:0]    r_count;
    logic          n_wr_idx;
    logic          n_rd_idx;
    logic [1:0]    n_count;
    logic          push;
    logic          pop;

    assign o_in_stall  = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_idx];

    // Drop the reserved kind at the door; queue everything else
    assign push = i_in_valid && !o_in_stall && (i_kind != otr_pkg::KIND_RESERVED);
    assign pop  = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_idx = r_wr_idx ^ push;
        n_rd_idx = r_rd_idx ^ pop;
        n_count  = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    // Capture the item into the queue slot
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_idx] <= '{kind:           i_kind,
                               sample_time:    i_sample_time,
                               record_payload: i_record_payload,
                               query_time:     i_query_time};
        end
    end

endmodule

// ===== hw/rtl/otr_back.sv =====
module otr_back #(
    parameter int RING_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    input  otr_pkg::t_cmd                      i_cmd,
    output logic                               o_cmd_pop,
    input  logic [otr_pkg::TIME_W-1:0]         i_window,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [otr_pkg::TYPE_W-1:0]         o_result_type,
    output logic [otr_pkg::ID_W-1:0]           o_record_id,
    output logic [otr_pkg::TIME_W-1:0]         o_entry_time,
    output logic [otr_pkg::PAYLOAD_W-1:0]      o_entry_payload,
    output logic [otr_pkg::COUNT_W-1:0]        o_held_count,
    output logic                               o_last_of_run
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int CW = otr_pkg::COUNT_W;
    localparam int TW = otr_pkg::TIME_W;
    localparam int EW = otr_pkg::ENTRY_W;
    localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FULL      = FW'(RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_IMPACT = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [PW-1:0]                 r_wptr, n_wptr;
    logic [FW-1:0]                 r_fill, n_fill;
    logic [otr_pkg::ID_W-1:0]      r_seq, n_seq;
    logic                          r_is_query, n_is_query;
    logic [TW-1:0]                 r_qtime, n_qtime;
    logic [TW-1:0]                 r_lo, n_lo;
    logic [PW-1:0]                 r_slot, n_slot;
    logic [FW-1:0]                 r_idx, n_idx;
    logic                          r_found, n_found;
    otr_pkg::t_entry               r_cand, n_cand;

    logic                          r_out_valid, n_out_valid;
    logic [otr_pkg::TYPE_W-1:0]    r_out_type, n_out_type;
    otr_pkg::t_entry               r_out_entry, n_out_entry;
    logic [CW-1:0]                 r_out_count, n_out_count;
    logic                          r_out_last, n_out_last;

    logic                          ram_we;
    logic                          ram_re;
    logic [PW-1:0]                 ram_raddr;
    logic [EW-1:0]                 ram_rdata;
    otr_pkg::t_entry               rd_entry;
    otr_pkg::t_entry               wr_entry;
    logic                          out_free;
    logic                          in_win;
    logic                          at_or_before;
    logic                          emit;
    logic                          last_entry;
    logic [PW-1:0]                 start_slot;

    // Ring storage, one word per entry
    otr_ram #(
        .WIDTH (EW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = ram_rdata;
    assign wr_entry = '{id: r_seq, etime: i_cmd.sample_time, payload: i_cmd.record_payload};

    // Output register frees up when empty or being taken this cycle
    assign out_free     = !r_out_valid || !i_out_stall;
    assign at_or_before = (rd_entry.etime <= r_qtime);
    assign in_win       = at_or_before && (rd_entry.etime >= r_lo);
    assign emit         = !r_is_query || in_win;
    assign last_entry   = (r_idx == (r_fill - FW'(1)));
    assign start_slot   = (r_fill < FULL) ? '0 : r_wptr;

    always_comb begin
        n_state     = r_state;
        n_wptr      = r_wptr;
        n_fill      = r_fill;
        n_seq       = r_seq;
        n_is_query  = r_is_query;
        n_qtime     = r_qtime;
        n_lo        = r_lo;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_found     = r_found;
        n_cand      = r_cand;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_type  = r_out_type;
        n_out_entry = r_out_entry;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_slot;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == otr_pkg::KIND_STORE) begin
                        // Stamp and write at the write pointer, overwrite when full
                        o_cmd_pop = 1'b1;
                        ram_we    = 1'b1;
                        n_wptr    = (r_wptr == LAST_SLOT) ? '0 : r_wptr + PW'(1);
                        n_seq     = r_seq + 32'd1;
                        if (r_fill < FULL) begin
                            n_fill = r_fill + FW'(1);
                        end
                    end else if (r_fill == '0) begin
                        // Empty ring: one empty marker
                        if (out_free) begin
                            o_cmd_pop   = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_type  = otr_pkg::RES_EMPTY;
                            n_out_entry = '0;
                            n_out_count = '0;
                            n_out_last  = 1'b1;
                        end
                    end else begin
                        // Start the walk at the oldest entry
                        o_cmd_pop  = 1'b1;
                        n_is_query = (i_cmd.kind == otr_pkg::KIND_QUERY);
                        n_qtime    = i_cmd.query_time;
                        n_lo       = (i_cmd.query_time >= i_window) ?
                                     i_cmd.query_time - i_window : '0;
                        n_found    = 1'b0;
                        n_idx      = '0;
                        n_slot     = start_slot;
                        ram_re     = 1'b1;
                        ram_raddr  = start_slot;
                        n_state    = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (!emit || out_free) begin
                    if (emit) begin
                        n_out_valid = 1'b1;
                        n_out_type  = r_is_query ? otr_pkg::RES_WINDOW : otr_pkg::RES_DUMP;
                        n_out_entry = rd_entry;
                        n_out_count = CW'(r_fill);
                        n_out_last  = !r_is_query && last_entry;
                    end
                    // Track the latest entry at or before the query time
                    if (r_is_query && at_or_before) begin
                        n_found = 1'b1;
                        n_cand  = rd_entry;
                    end
                    if (last_entry) begin
                        n_state = r_is_query ? S_IMPACT : S_IDLE;
                    end else begin
                        // Advance and fetch the next entry
                        n_idx     = r_idx + FW'(1);
                        n_slot    = (r_slot == LAST_SLOT) ? '0 : r_slot + PW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = n_slot;
                    end
                end
            end
            S_IMPACT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_type  = otr_pkg::RES_IMPACT;
                    n_out_entry = r_found ? r_cand : '0;
                    n_out_count = CW'(r_fill);
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_fill      <= '0;
            r_seq       <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_fill      <= n_fill;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    // Walk context and result payload
    always_ff @(posedge i_clk) begin
        r_is_query  <= n_is_query;
        r_qtime     <= n_qtime;
        r_lo        <= n_lo;
        r_slot      <= n_slot;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_cand      <= n_cand;
        r_out_type  <= n_out_type;
        r_out_entry <= n_out_entry;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_type   = r_out_type;
    assign o_record_id     = r_out_entry.id;
    assign o_entry_time    = r_out_entry.etime;
    assign o_entry_payload = r_out_entry.payload;
    assign o_held_count    = r_out_count;
    assign o_last_of_run   = r_out_last;

endmodule

// ===== hw/rtl/overwriting_trace_recorder_top.sv =====
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  ---------------------------------------------
// in       to block   i_in_valid/o_in_stall  kind, sample_time, record_payload, query_time
// out      from block o_out_valid/i_out_stall result_type, record_id, entry_time,
//                                            entry_payload, held_count, last_of_run
// cfg      to block   APB psel/penable       window_length at byte address 0
//
// A store needs no walk in the back engine; a reserved kind is dropped at the input.
// A dump or query walks the held entries from the oldest, and a query then adds the impact
// record; one entry per cycle through the single read port of the ring RAM unless stalled.
// A two-entry queue lets the input side accept up to two items while a walk is in progress.
// Reset is synchronous: pointer, fill level, sequence (to 1) and window are restored;
// ring contents are not cleared. Output stall holds the walk on the pending entry.
module overwriting_trace_recorder_top #(
    parameter int RING_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [otr_pkg::KIND_W-1:0]         i_kind,
    input  logic [otr_pkg::TIME_W-1:0]         i_sample_time,
    input  logic [otr_pkg::PAYLOAD_W-1:0]      i_record_payload,
    input  logic [otr_pkg::TIME_W-1:0]         i_query_time,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [otr_pkg::TYPE_W-1:0]         o_result_type,
    output logic [otr_pkg::ID_W-1:0]           o_record_id,
    output logic [otr_pkg::TIME_W-1:0]         o_entry_time,
    output logic [otr_pkg::PAYLOAD_W-1:0]      o_entry_payload,
    output logic [otr_pkg::COUNT_W-1:0]        o_held_count,
    output logic                               o_last_of_run,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [otr_pkg::TIME_W-1:0] r_window;
    logic                       cfg_wr;
    logic                       cmd_valid;
    logic                       cmd_pop;
    otr_pkg::t_cmd              cmd;

    // Register file: one window register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == otr_pkg::REG_WINDOW);
    assign prdata = (paddr[2] == otr_pkg::REG_WINDOW) ? 32'(r_window) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= otr_pkg::WINDOW_RESET;
        end else if (cfg_wr) begin
            r_window <= pwdata[otr_pkg::TIME_W-1:0];
        end
    end

    // Front: accept, classify, queue
    otr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_sample_time    (i_sample_time),
        .i_record_payload (i_record_payload),
        .i_query_time     (i_query_time),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd),
        .i_cmd_pop        (cmd_pop)
    );

    // Back: ring storage and walks
    otr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .i_window        (r_window),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_type   (o_result_type),
        .o_record_id     (o_record_id),
        .o_entry_time    (o_entry_time),
        .o_entry_payload (o_entry_payload),
        .o_held_count    (o_held_count),
        .o_last_of_run   (o_last_of_run)
    );

endmodule
